// ----- hw/rtl/stq_pkg.sv -----
// stq_pkg: widths, command codes and the list entry type of the sorted timer queue
// no dependencies; used by the interfaces, the list memory and the top level
`timescale 1ns / 1ps

package stq_pkg;

  localparam int MODE_W = 2;
  localparam int ID_W = 6;
  localparam int TIME_W = 63;
  localparam int DLY_W = 32;
  localparam int TPM_W = 24;
  localparam int CNT_W = 7;
  localparam int PROD_W = TPM_W + DLY_W;

  localparam int DEF_NUM_TIMERS = 64;
  localparam logic [TPM_W-1:0] TPM_RESET = 24'd14112;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_ARM_ABS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARM_DELAY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TIME_W-1:0] dl;
  } entry_t;

endpackage

// ----- hw/rtl/stq_if.sv -----
// stq_cmd_if / stq_rsp_if: valid/ready channels of the sorted timer queue
// depends on stq_pkg
`timescale 1ns / 1ps

interface stq_cmd_if;
  logic valid;
  logic ready;
  logic [stq_pkg::MODE_W-1:0] mode;
  logic [stq_pkg::ID_W-1:0] timer_id;
  logic [stq_pkg::TIME_W-1:0] time_value;
  logic [stq_pkg::DLY_W-1:0] delay_msec;

  modport source (output valid, mode, timer_id, time_value, delay_msec, input ready);
  modport sink (input valid, mode, timer_id, time_value, delay_msec, output ready);
endinterface

interface stq_rsp_if;
  logic valid;
  logic ready;
  logic expired_valid;
  logic [stq_pkg::ID_W-1:0] expired_id;
  logic [stq_pkg::TIME_W-1:0] expired_time;
  logic [stq_pkg::TIME_W-1:0] now_time;
  logic [stq_pkg::CNT_W-1:0] armed_count;
  logic last;

  modport source (output valid, expired_valid, expired_id, expired_time, now_time,
                  armed_count, last, input ready);
  modport sink (input valid, expired_valid, expired_id, expired_time, now_time,
                armed_count, last, output ready);
endinterface

// ----- hw/rtl/sorted_timer_queue.sv -----
// sorted_timer_queue: timer list kept in deadline order in one memory, with logical time
// depends on stq_pkg, stq_if (stq_cmd_if, stq_rsp_if) and stq_mem
//
//   channel | dir | handshake     | payload
//   cmd     | in  | valid/ready   | mode, timer_id, time_value, delay_msec
//   rsp     | out | valid/ready   | expired_valid/id/time, now_time, armed_count, last
//   cfg     | in  | cfg_wr_en     | cfg_wr_data = ticks_per_msec
//
// one command at a time
// cancel: a remove walk if armed; arm: remove walk (only if armed) plus insert walk
// delayed arm first does the 24x32 multiply and then the saturating add
// advance: reads the head, then a remove walk and a result per expired timer
// the walks are bound by one list entry read and written per cycle in stq_mem
// rst is synchronous; a waiting result holds the block only when the next result is ready
`timescale 1ns / 1ps

module sorted_timer_queue #(
  parameter int NUM_TIMERS = stq_pkg::DEF_NUM_TIMERS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [stq_pkg::TPM_W-1:0] cfg_wr_data,
  stq_cmd_if.sink                   cmd,
  stq_rsp_if.source                 rsp
);
  import stq_pkg::*;

  localparam int AW = $clog2(NUM_TIMERS);
  localparam int LW = $clog2(NUM_TIMERS + 1);
  localparam int FLAGS = (NUM_TIMERS < 64) ? NUM_TIMERS : 64;
  localparam int FW = (FLAGS > 1) ? $clog2(FLAGS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL = 4'd1;
  localparam logic [3:0] S_ADD = 4'd2;
  localparam logic [3:0] S_REM = 4'd3;
  localparam logic [3:0] S_INS = 4'd4;
  localparam logic [3:0] S_ADV_RD = 4'd5;
  localparam logic [3:0] S_ADV_CHK = 4'd6;
  localparam logic [3:0] S_POP_OUT = 4'd7;
  localparam logic [3:0] S_STATUS = 4'd8;

  logic [3:0] state;
  logic [TPM_W-1:0] tpm;
  logic [TIME_W-1:0] cur_time;
  logic [LW-1:0] length;
  logic [FLAGS-1:0] armed;

  logic [MODE_W-1:0] mode_r;
  logic [ID_W-1:0] id_r;
  logic [TIME_W-1:0] tv_r;
  logic [DLY_W-1:0] dm_r;
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] new_dl;
  logic [ID_W-1:0] rem_id;

  logic [LW-1:0] ridx;
  logic pvalid;
  logic [AW-1:0] ppos;
  logic found;
  logic placed;
  entry_t carry;
  entry_t hd;
  logic due_r;
  logic popped;
  logic [ID_W-1:0] pop_id;
  logic [TIME_W-1:0] pop_dl;

  logic out_valid;
  logic out_exp;
  logic [ID_W-1:0] out_id;
  logic [TIME_W-1:0] out_time;
  logic [TIME_W-1:0] out_now;
  logic [CNT_W-1:0] out_cnt;
  logic out_last;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t rdata;

  logic walking;
  logic rd_issue;
  logic walk_done;
  logic gt;
  logic slot_free;
  logic out_load;
  logic cmd_xfer;
  logic id_ok;
  logic [FW-1:0] cmd_fidx;
  logic [TIME_W:0] dly_sum;
  logic [LW-1:0] len_after_rem;
  logic head_due;
  entry_t new_entry;

  stq_mem #(.DEPTH(NUM_TIMERS)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  assign walking = (state == S_REM) || (state == S_INS);
  assign rd_issue = walking && (ridx < length);
  assign walk_done = walking && !pvalid && !rd_issue;
  assign gt = rdata.dl > new_dl;
  assign slot_free = !out_valid || rsp.ready;
  assign out_load = ((state == S_POP_OUT) || (state == S_STATUS)) && slot_free;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_xfer = cmd.valid && cmd.ready;
  assign id_ok = {1'b0, cmd.timer_id} < 7'(FLAGS);
  assign cmd_fidx = FW'(cmd.timer_id);
  assign dly_sum = {1'b0, cur_time} + (TIME_W + 1)'(prod);
  assign len_after_rem = found ? length - LW'(1) : length;
  assign head_due = (length != '0) && (rdata.dl <= tv_r);
  assign new_entry = '{id: id_r, dl: new_dl};
  assign mem_raddr = (state == S_ADV_RD) ? '0 : ridx[AW-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = ppos;
    mem_wdata = carry;
    if (state == S_REM) begin
      // close the gap behind the removed entry
      mem_we = pvalid && found;
      mem_waddr = ppos - AW'(1);
      mem_wdata = rdata;
    end else if (state == S_INS) begin
      if (pvalid) begin
        mem_we = placed || gt;
        mem_waddr = ppos;
        mem_wdata = placed ? carry : new_entry;
      end else if (walk_done) begin
        mem_we = 1'b1;
        mem_waddr = length[AW-1:0];
        mem_wdata = placed ? carry : new_entry;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.expired_valid = out_exp;
  assign rsp.expired_id = out_id;
  assign rsp.expired_time = out_time;
  assign rsp.now_time = out_now;
  assign rsp.armed_count = out_cnt;
  assign rsp.last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tpm <= TPM_RESET;
      cur_time <= '0;
      length <= '0;
      armed <= '0;
      out_valid <= 1'b0;
      pvalid <= 1'b0;
      popped <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tpm <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (walking) begin
        pvalid <= rd_issue;
        if (rd_issue) begin
          ridx <= ridx + LW'(1);
          ppos <= ridx[AW-1:0];
        end
      end

      case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            mode_r <= cmd.mode;
            id_r <= cmd.timer_id;
            tv_r <= cmd.time_value;
            dm_r <= cmd.delay_msec;
            rem_id <= cmd.timer_id;
            new_dl <= (cmd.time_value < cur_time) ? cur_time : cmd.time_value;
            ridx <= '0;
            pvalid <= 1'b0;
            found <= 1'b0;
            placed <= 1'b0;
            popped <= 1'b0;
            if (cmd.mode == MODE_ADVANCE) begin
              state <= S_ADV_RD;
            end else if (!id_ok) begin
              state <= S_STATUS;
            end else if (cmd.mode == MODE_ARM_DELAY) begin
              state <= S_MUL;
            end else if (armed[cmd_fidx]) begin
              state <= S_REM;
            end else if (cmd.mode == MODE_CANCEL) begin
              state <= S_STATUS;
            end else begin
              state <= (length < LW'(NUM_TIMERS)) ? S_INS : S_STATUS;
            end
          end
        end

        S_MUL: begin
          prod <= tpm * dm_r;
          state <= S_ADD;
        end

        S_ADD: begin
          new_dl <= dly_sum[TIME_W] ? TIME_MAX : dly_sum[TIME_W-1:0];
          if (armed[FW'(id_r)]) begin
            state <= S_REM;
          end else begin
            state <= (length < LW'(NUM_TIMERS)) ? S_INS : S_STATUS;
          end
        end

        S_REM: begin
          if (pvalid && !found && rdata.id == rem_id) begin
            found <= 1'b1;
          end
          if (walk_done) begin
            length <= len_after_rem;
            armed[FW'(rem_id)] <= 1'b0;
            ridx <= '0;
            found <= 1'b0;
            placed <= 1'b0;
            if (mode_r == MODE_ADVANCE) begin
              state <= S_ADV_RD;
            end else if (mode_r == MODE_CANCEL) begin
              state <= S_STATUS;
            end else begin
              state <= (len_after_rem < LW'(NUM_TIMERS)) ? S_INS : S_STATUS;
            end
          end
        end

        S_INS: begin
          if (pvalid && (placed || gt)) begin
            carry <= rdata;
            placed <= 1'b1;
          end
          if (walk_done) begin
            length <= length + LW'(1);
            armed[FW'(id_r)] <= 1'b1;
            state <= S_STATUS;
          end
        end

        S_ADV_RD: begin
          state <= S_ADV_CHK;
        end

        S_ADV_CHK: begin
          hd <= rdata;
          due_r <= head_due;
          if (popped) begin
            state <= S_POP_OUT;
          end else if (head_due) begin
            // first pop of this advance
            pop_id <= rdata.id;
            pop_dl <= rdata.dl;
            cur_time <= rdata.dl;
            rem_id <= rdata.id;
            ridx <= '0;
            pvalid <= 1'b0;
            found <= 1'b0;
            popped <= 1'b1;
            state <= S_REM;
          end else begin
            cur_time <= tv_r;
            state <= S_STATUS;
          end
        end

        S_POP_OUT: begin
          if (slot_free) begin
            out_exp <= 1'b1;
            out_id <= pop_id;
            out_time <= pop_dl;
            out_now <= due_r ? pop_dl : tv_r;
            out_cnt <= CNT_W'(length);
            out_last <= !due_r;
            if (due_r) begin
              pop_id <= hd.id;
              pop_dl <= hd.dl;
              cur_time <= hd.dl;
              rem_id <= hd.id;
              ridx <= '0;
              pvalid <= 1'b0;
              found <= 1'b0;
              state <= S_REM;
            end else begin
              cur_time <= tv_r;
              popped <= 1'b0;
              state <= S_IDLE;
            end
          end
        end

        S_STATUS: begin
          if (slot_free) begin
            out_exp <= 1'b0;
            out_id <= '0;
            out_time <= '0;
            out_now <= cur_time;
            out_cnt <= CNT_W'(length);
            out_last <= 1'b1;
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/stq_mem.sv -----
// stq_mem: sorted list storage, one write and one registered read port
// depends on stq_pkg
`timescale 1ns / 1ps

module stq_mem #(
  parameter int DEPTH = stq_pkg::DEF_NUM_TIMERS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  stq_pkg::entry_t          wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output stq_pkg::entry_t          rdata
);
  import stq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/stq_checker.sv -----
// stq_checker: port-level assertions for sorted_timer_queue, bound to the top level
// depends on stq_pkg and sorted_timer_queue
`timescale 1ns / 1ps

module stq_checker #(
  parameter int NUM_TIMERS = stq_pkg::DEF_NUM_TIMERS
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_expired_valid,
  input logic [stq_pkg::ID_W-1:0]   rsp_expired_id,
  input logic [stq_pkg::TIME_W-1:0] rsp_now_time,
  input logic [stq_pkg::CNT_W-1:0]  rsp_armed_count,
  input logic                       rsp_last
);
  import stq_pkg::*;

  // a stalled result stays valid and keeps its now_time and expired_id
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_now_time) && $stable(rsp_expired_id))
    else $error("result changed while stalled");

  // no new command while an advance still has expiries to report
  a_busy_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !cmd_ready)
    else $error("command taken in the middle of an advance");

  // a status result closes its command and carries id zero
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_expired_valid |-> rsp_last && rsp_expired_id == '0)
    else $error("status result not last or carries an id");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp_armed_count) <= 32'(NUM_TIMERS))
    else $error("armed count above timer count");

endmodule

bind sorted_timer_queue stq_checker #(.NUM_TIMERS(NUM_TIMERS)) u_stq_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_ready        (cmd.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_expired_valid(rsp.expired_valid),
  .rsp_expired_id   (rsp.expired_id),
  .rsp_now_time     (rsp.now_time),
  .rsp_armed_count  (rsp.armed_count),
  .rsp_last         (rsp.last)
);

// ----- tb/tb_sorted_timer_queue.sv -----
// tb_sorted_timer_queue: self-checking bench for the sorted timer queue
// depends on stq_pkg, stq_if and the sorted_timer_queue rtl
`timescale 1ns / 1ps

module tb_sorted_timer_queue;
  import stq_pkg::*;

  localparam int NT = DEF_NUM_TIMERS;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic expired_valid;
    logic [ID_W-1:0] expired_id;
    logic [TIME_W-1:0] expired_time;
    logic [TIME_W-1:0] now_time;
    logic [CNT_W-1:0] armed_count;
    logic last;
  } expiry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [TPM_W-1:0] cfg_wr_data = '0;

  stq_cmd_if cmd ();
  stq_rsp_if rsp ();

  sorted_timer_queue u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd(cmd.sink), .rsp(rsp.source)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the timer list
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] dl_q[$];
  logic [ID_W-1:0] id_q[$];
  bit armed_q[NT];
  logic [TPM_W-1:0] tpm_q;

  expiry_t expiry_fifo[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_rsp = 1'b0;
  bit quiet = 1'b0;

  function automatic void drop_timer(logic [ID_W-1:0] id);
    if (!armed_q[id]) return;
    foreach (id_q[i]) begin
      if (id_q[i] == id) begin
        id_q.delete(i);
        dl_q.delete(i);
        break;
      end
    end
    armed_q[id] = 1'b0;
  endfunction

  function automatic void insert_timer(logic [ID_W-1:0] id, logic [TIME_W-1:0] dl);
    int pos;
    if (dl < now_q) dl = now_q;
    drop_timer(id);
    if (id_q.size() >= NT) return;
    pos = id_q.size();
    foreach (dl_q[i]) begin
      if (dl_q[i] > dl) begin
        pos = i;
        break;
      end
    end
    id_q.insert(pos, id);
    dl_q.insert(pos, dl);
    armed_q[id] = 1'b1;
  endfunction

  function automatic void predict_expiries(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                           logic [TIME_W-1:0] tv, logic [DLY_W-1:0] dm);
    expiry_t e;
    logic [TIME_W+1:0] sum;
    bit any;
    any = 1'b0;
    if (mode == MODE_ADVANCE) begin
      while (id_q.size() > 0 && dl_q[0] <= tv) begin
        e = '0;
        e.expired_valid = 1'b1;
        e.expired_id = id_q[0];
        e.expired_time = dl_q[0];
        now_q = dl_q[0];
        drop_timer(id_q[0]);
        e.last = (id_q.size() == 0 || dl_q[0] > tv);
        if (e.last) now_q = tv;
        e.now_time = now_q;
        e.armed_count = CNT_W'(id_q.size());
        expiry_fifo.push_back(e);
        any = 1'b1;
      end
      if (!any) now_q = tv;
    end else begin
      if (mode == MODE_ARM_ABS) insert_timer(id, tv);
      else if (mode == MODE_ARM_DELAY) begin
        sum = {1'b0, 64'(now_q)} + 65'(tpm_q) * 65'(dm);
        insert_timer(id, (sum > 65'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0]);
      end else drop_timer(id);
    end
    if (!any) begin
      e = '0;
      e.now_time = now_q;
      e.armed_count = CNT_W'(id_q.size());
      e.last = 1'b1;
      expiry_fifo.push_back(e);
    end
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one command, wait for its transfer; valid stays up for a back-to-back follow-up
  task automatic send_cmd(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                          logic [TIME_W-1:0] tv, logic [DLY_W-1:0] dm);
    int gap;
    gap = quiet ? 0 : rand_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.mode <= mode;
    cmd.timer_id <= id;
    cmd.time_value <= tv;
    cmd.delay_msec <= dm;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predict_expiries(mode, id, tv, dm);
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    while (expiry_fifo.size() > 0) @(posedge clk);
    // extra idle margin after the last result has been taken
    repeat (3 * NT + 20) @(posedge clk);
  endtask

  task automatic write_tpm(logic [TPM_W-1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tpm_q = v;
  endtask

  function automatic logic [TIME_W-1:0] rand_time63();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [TIME_W-1:0] near_time();
    return now_q + $urandom_range(0, 2000);
  endfunction

  // response side: random stalls, check each transfer
  initial begin
    int gap;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = hold_rsp ? 0 : rand_gap();
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        @(posedge clk);
      end else if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    expiry_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.expired_valid, rsp.expired_id, rsp.expired_time, rsp.now_time,
             rsp.armed_count, rsp.last};
      if (expiry_fifo.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = expiry_fifo.pop_front();
        if (got.expired_valid !== want.expired_valid)
          $display("%0t: expired_valid exp %0d act %0d", $time, want.expired_valid,
                   got.expired_valid);
        if (got.expired_id !== want.expired_id)
          $display("%0t: expired_id exp %0d act %0d", $time, want.expired_id, got.expired_id);
        if (got.expired_time !== want.expired_time)
          $display("%0t: expired_time exp %0d act %0d", $time, want.expired_time,
                   got.expired_time);
        if (got.now_time !== want.now_time)
          $display("%0t: now_time exp %0d act %0d", $time, want.now_time, got.now_time);
        if (got.armed_count !== want.armed_count)
          $display("%0t: armed_count exp %0d act %0d", $time, want.armed_count,
                   got.armed_count);
        if (got.last !== want.last)
          $display("%0t: last exp %0d act %0d", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog on cycles with no transfer while something is pending
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
        (expiry_fifo.size() == 0 && !cmd.valid))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_cmd(MODE_ADVANCE, 6'd0, 63'd0, 32'd0);
    send_cmd(MODE_ARM_ABS, 6'd0, 63'd100, 32'd0);
    send_cmd(MODE_ARM_ABS, 6'd63, 63'd100, 32'hFFFF_FFFF);
    send_cmd(MODE_ARM_ABS, 6'd5, 63'd50, 32'd0);
    send_cmd(MODE_ARM_DELAY, 6'd7, '0, 32'd0);
    send_cmd(MODE_ARM_DELAY, 6'd8, '0, 32'd1);
    send_cmd(MODE_ARM_ABS, 6'd5, 63'd100, 32'd0);
    send_cmd(MODE_CANCEL, 6'd9, '0, 32'd0);
    send_cmd(MODE_CANCEL, 6'd0, TIME_MAX, 32'd0);
    send_cmd(MODE_ADVANCE, 6'd63, 63'd100, 32'd0);
    send_cmd(MODE_ARM_ABS, 6'd1, 63'd3, 32'd0);
    send_cmd(MODE_ARM_ABS, 6'd2, 63'd500, 32'd0);
    send_cmd(MODE_ADVANCE, 6'd0, 63'd10, 32'd0);
    send_cmd(MODE_ARM_DELAY, 6'd3, '0, 32'hFFFF_FFFF);
    send_cmd(MODE_ARM_ABS, 6'd4, TIME_MAX, 32'd0);
    send_cmd(MODE_ADVANCE, 6'd0, TIME_MAX, 32'd0);
    send_cmd(MODE_ARM_DELAY, 6'd6, '0, 32'd5);
    send_cmd(MODE_ADVANCE, 6'd0, 63'd0, 32'd0);
  endtask

  task automatic test_random(int n);
    int k, r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_cmd(MODE_ARM_ABS, ID_W'($urandom()),
                           ($urandom_range(0, 19) == 0) ? rand_time63() : near_time(), $urandom());
      else if (r < 55) send_cmd(MODE_ARM_DELAY, ID_W'($urandom()), rand_time63(),
                                ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 3));
      else if (r < 70) send_cmd(MODE_CANCEL, ID_W'($urandom()), rand_time63(), $urandom());
      else send_cmd(MODE_ADVANCE, ID_W'($urandom()),
                    ($urandom_range(0, 14) == 0) ? rand_time63() :
                    (($urandom_range(0, 9) == 0) ? now_q - $urandom_range(0, 500) : near_time()),
                    $urandom());
    end
  endtask

  task automatic test_backpressure();
    int k;
    hold_rsp = 1'b1;
    fork
      begin
        repeat (800) @(posedge clk);
        hold_rsp = 1'b0;
      end
      for (k = 0; k < 12; k++) send_cmd(MODE_ARM_ABS, ID_W'(k), near_time(), 32'd0);
    join
  endtask

  task automatic test_full_list();
    int k;
    wait_drained();
    quiet = 1'b1;
    for (k = 0; k < NT; k++)
      send_cmd(MODE_ARM_ABS, ID_W'(k), now_q + $urandom_range(0, 40), 32'd0);
    send_cmd(MODE_ARM_ABS, 6'd10, now_q + 63'd20, 32'd0);
    quiet = 1'b0;
    send_cmd(MODE_ADVANCE, 6'd0, now_q + 63'd100, 32'd0);
  endtask

  initial begin
    tpm_q = TPM_RESET;
    now_q = '0;
    cmd.valid = 1'b0;
    cmd.mode = MODE_ARM_ABS;
    cmd.timer_id = '0;
    cmd.time_value = '0;
    cmd.delay_msec = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_full_list();
    test_random(80);
    write_tpm(24'd1);
    test_random(80);
    write_tpm(24'hFF_FFFF);
    send_cmd(MODE_ARM_DELAY, 6'd11, '0, 32'hFFFF_FFFF);
    test_random(80);
    write_tpm(24'd0);
    send_cmd(MODE_ARM_DELAY, 6'd12, '0, 32'd7);
    test_random(40);
    write_tpm(24'd37);
    test_random(60);
    send_cmd(MODE_ADVANCE, 6'd0, TIME_MAX, 32'd0);
    wait_drained();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
